// ----- sv/csscs_pkg.sv -----
// Shared types and constants for the comment stripper.
package csscs_pkg;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	// scan mode codes
	localparam logic [2:0] MODE_PLAIN   = 3'd0;
	localparam logic [2:0] MODE_SQUOTE  = 3'd1;
	localparam logic [2:0] MODE_DQUOTE  = 3'd2;
	localparam logic [2:0] MODE_SLASH   = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;
	localparam logic [2:0] MODE_STAR    = 3'd5;

	// character codes
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// results of one scanned word: zero, one or two output words
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] byte0;
		logic       last0;
		logic [7:0] byte1;
	} push_t;

endpackage

// ----- sv/css_comment_stripper.sv -----
// Top level of the block-comment stripper.
// Usage:
//   Input channel (in_valid / in_stall / in_byte) carries one text word per
//   handshake; a word is taken at a rising edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall / out_byte / last)
//   returns the text with slash-star comments removed; last marks the final
//   word caused by one input word.
// Flow: a taken word sits in the scan register, is decoded and written to the
//   result queue when the scan stage advances, and can then be taken from the
//   output.
// Throughput: one input word per cycle while the queue has room. The scan
//   register advances only when the four-entry result queue has two free
//   entries, so a word that releases a held slash writes two results and,
//   with a busy output, backs up into in_stall.
// Stall: while out_stall is high the queue holds its head word steady; once
//   fewer than two entries are free, the scan stage holds and in_stall rises.
//   Input is still taken while earlier results wait in the queue.
// Reset: arst_n clears the scan mode to plain text and empties the queue;
//   a slash still held at the end of a stream is never released.
module css_comment_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last
);

	csscs_pkg::push_t push;
	logic             room;

	// decode one word per cycle, while the queue has room, into zero, one or two results
	csscs_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.room     (room),
		.push     (push)
	);

	// hold results until the receiver takes them
	csscs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ----- sv/csscs_scan.sv -----
// Input register and scan-mode decode for the comment stripper.
module csscs_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	input  logic                 room,
	output csscs_pkg::push_t     push
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] mode_q;
	logic [2:0] mode_nxt;
	logic       advance;
	logic       take;

	assign advance  = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csscs_pkg::MODE_PLAIN;
		end else if (advance) begin
			mode_q <= mode_nxt;
		end
	end

	always_comb begin
		mode_nxt   = mode_q;
		push.n     = 2'd0;
		push.byte0 = byte_s1;
		push.last0 = 1'b1;
		push.byte1 = byte_s1;
		unique case (mode_q)
			csscs_pkg::MODE_SQUOTE: begin
				if (byte_s1 == csscs_pkg::CH_SQUOTE) mode_nxt = csscs_pkg::MODE_PLAIN;
				push.n = 2'd1;
			end
			csscs_pkg::MODE_DQUOTE: begin
				if (byte_s1 == csscs_pkg::CH_DQUOTE) mode_nxt = csscs_pkg::MODE_PLAIN;
				push.n = 2'd1;
			end
			csscs_pkg::MODE_SLASH: begin
				priority if (byte_s1 == csscs_pkg::CH_SLASH) begin
					push.n = 2'd1;
				end else if (byte_s1 == csscs_pkg::CH_STAR) begin
					mode_nxt = csscs_pkg::MODE_COMMENT;
				end else begin
					// release the held slash, then the word itself
					mode_nxt   = csscs_pkg::MODE_PLAIN;
					push.n     = 2'd2;
					push.byte0 = csscs_pkg::CH_SLASH;
					push.last0 = 1'b0;
				end
			end
			csscs_pkg::MODE_COMMENT: begin
				if (byte_s1 == csscs_pkg::CH_STAR) mode_nxt = csscs_pkg::MODE_STAR;
			end
			csscs_pkg::MODE_STAR: begin
				priority if (byte_s1 == csscs_pkg::CH_SLASH) begin
					mode_nxt = csscs_pkg::MODE_PLAIN;
				end else if (byte_s1 != csscs_pkg::CH_STAR) begin
					mode_nxt = csscs_pkg::MODE_COMMENT;
				end else begin
					mode_nxt = csscs_pkg::MODE_STAR;
				end
			end
			default: begin
				priority if (byte_s1 == csscs_pkg::CH_SLASH) begin
					mode_nxt = csscs_pkg::MODE_SLASH;
				end else if (byte_s1 == csscs_pkg::CH_SQUOTE) begin
					mode_nxt = csscs_pkg::MODE_SQUOTE;
					push.n   = 2'd1;
				end else if (byte_s1 == csscs_pkg::CH_DQUOTE) begin
					mode_nxt = csscs_pkg::MODE_DQUOTE;
					push.n   = 2'd1;
				end else begin
					mode_nxt = csscs_pkg::MODE_PLAIN;
					push.n   = 2'd1;
				end
			end
		endcase
		if (!advance) push.n = 2'd0;
	end

endmodule

// ----- sv/csscs_outq.sv -----
// Small result queue between the scan stage and the output channel.
module csscs_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csscs_pkg::push_t     push,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 last
);

	localparam int CntW = csscs_pkg::QAw + 1;

	logic [8:0]                     mem_q [csscs_pkg::QDepth];
	logic [csscs_pkg::QAw-1:0]      wr_q;
	logic [csscs_pkg::QAw-1:0]      rd_q;
	logic [CntW-1:0]                count_q;
	logic                           pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & ~out_stall;
	// two free entries cover the largest result group
	assign room      = (count_q <= CntW'(csscs_pkg::QDepth - 2));
	assign out_byte  = mem_q[rd_q][8:1];
	assign last      = mem_q[rd_q][0];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= {push.byte0, push.last0};
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + csscs_pkg::QAw'(1)] <= {push.byte1, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + csscs_pkg::QAw'(push.n);
			if (pop) rd_q <= rd_q + csscs_pkg::QAw'(1);
			count_q <= count_q + CntW'(push.n) - CntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (32'(count_q) + 32'(push.n) <= csscs_pkg::QDepth))
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= csscs_pkg::QDepth)
		else $error("result queue count out of range");

	a_pop_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.n == 2'd0) |=> (count_q == $past(count_q) - CntW'(1)))
		else $error("result queue count did not drain");

endmodule

// ----- dv/tb_css_comment_stripper.sv -----
// Self-checking testbench for the block-comment stripper.
module tb_css_comment_stripper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdlePct   = 24;      // chance in a hundred that a side idles
	localparam int TextWords = 1400;    // minimum length of the whole text
	localparam int CalmFrom  = 500;     // no idling on either side in this span
	localparam int CalmTo    = 800;
	localparam int TailWait  = 16;      // covers the scan register and result queue with margin
	localparam int CycleCap  = 200000;  // hard stop for a hung run

	// one expected output word
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} strip_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       last;

	logic [7:0]  text_q[$];    // raw text still to be sent
	strip_word_t kept_q[$];    // words the stripper must still produce
	logic [2:0]  scan_st;      // predicted scan mode
	int          taken_cnt;
	int          errors;
	int          cycles;
	logic        calm;

	assign calm = taken_cnt >= CalmFrom && taken_cnt < CalmTo;

	css_comment_stripper u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Advance the predicted scan mode by one raw word and queue what it releases.
	function automatic void strip_predict(input logic [7:0] c);
		case (scan_st)
			csscs_pkg::MODE_SQUOTE: begin
				if (c == csscs_pkg::CH_SQUOTE) scan_st = csscs_pkg::MODE_PLAIN;
				kept_q.push_back({c, 1'b1});
			end
			csscs_pkg::MODE_DQUOTE: begin
				if (c == csscs_pkg::CH_DQUOTE) scan_st = csscs_pkg::MODE_PLAIN;
				kept_q.push_back({c, 1'b1});
			end
			csscs_pkg::MODE_SLASH: begin
				// a second slash releases one and keeps holding
				if (c == csscs_pkg::CH_SLASH) begin
					kept_q.push_back({csscs_pkg::CH_SLASH, 1'b1});
				end else if (c == csscs_pkg::CH_STAR) begin
					scan_st = csscs_pkg::MODE_COMMENT;
				end else begin
					// release the held slash, then the word; quotes do not open here
					scan_st = csscs_pkg::MODE_PLAIN;
					kept_q.push_back({csscs_pkg::CH_SLASH, 1'b0});
					kept_q.push_back({c, 1'b1});
				end
			end
			csscs_pkg::MODE_COMMENT: begin
				if (c == csscs_pkg::CH_STAR) scan_st = csscs_pkg::MODE_STAR;
			end
			csscs_pkg::MODE_STAR: begin
				// stay on repeated stars, close on slash, else drop back inside
				if (c == csscs_pkg::CH_SLASH) scan_st = csscs_pkg::MODE_PLAIN;
				else if (c != csscs_pkg::CH_STAR) scan_st = csscs_pkg::MODE_COMMENT;
			end
			default: begin
				if (c == csscs_pkg::CH_SLASH) begin
					scan_st = csscs_pkg::MODE_SLASH;
				end else begin
					if (c == csscs_pkg::CH_SQUOTE) scan_st = csscs_pkg::MODE_SQUOTE;
					else if (c == csscs_pkg::CH_DQUOTE) scan_st = csscs_pkg::MODE_DQUOTE;
					else scan_st = csscs_pkg::MODE_PLAIN;
					kept_q.push_back({c, 1'b1});
				end
			end
		endcase
	endfunction

	task automatic report(input string what, input int unsigned want, input int unsigned got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0h, actual %0h", what, want, got);
	endtask

	task automatic check_word(input logic [7:0] ch, input logic fin);
		strip_word_t w;
		if (kept_q.size() == 0) begin
			report("unexpected output word", 0, 32'(ch));
		end else begin
			w = kept_q.pop_front();
			if (ch !== w.ch) report("out_byte", 32'(w.ch), 32'(ch));
			if (fin !== w.fin) report("last", 32'(w.fin), 32'(fin));
		end
	endtask

	// Pick a text word, leaning hard on the characters that steer the scan.
	function automatic logic [7:0] text_char();
		case ($urandom_range(0, 7))
			0: return csscs_pkg::CH_SLASH;
			1: return csscs_pkg::CH_STAR;
			2: return csscs_pkg::CH_SQUOTE;
			3: return csscs_pkg::CH_DQUOTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	task automatic build_text();
		int         n;
		logic [7:0] q;
		logic [7:0] c;
		// directed: byte extremes, slash released by a quote, markers inside
		// both kinds of quotes, slash after slash then a comment with
		// repeated stars and a drop back from star-seen
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		push_str("/'");
		push_str("'/*'");
		push_str("\"*/\"");
		push_str("//*a**b*/");
		// random: mostly well-formed pieces with random content, some noise
		while (text_q.size() < TextWords) begin
			n = $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (n) text_q.push_back(text_char());
				end
				3, 4: begin
					push_str("/*");
					repeat (n) text_q.push_back(text_char());
					push_str("*/");
				end
				5, 6: begin
					q = $urandom_range(0, 1) ? csscs_pkg::CH_SQUOTE : csscs_pkg::CH_DQUOTE;
					text_q.push_back(q);
					repeat (n) begin
						do c = text_char(); while (c == q);
						text_q.push_back(c);
					end
					text_q.push_back(q);
				end
				7: begin
					repeat ($urandom_range(1, 4)) text_q.push_back(csscs_pkg::CH_SLASH);
					text_q.push_back(text_char());
				end
				8: begin
					repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
				end
				default: begin
					// broken piece: an opener with no close
					if ($urandom_range(0, 1)) push_str("/*");
					else text_q.push_back(text_char() == csscs_pkg::CH_STAR ?
						csscs_pkg::CH_SQUOTE : csscs_pkg::CH_DQUOTE);
					repeat (n / 2) text_q.push_back(text_char());
				end
			endcase
		end
		// end on a slash that is never released
		push_str("/*x*/ /");
	endtask

	// Driver: present the next raw word; hold it while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
		end else begin
			if (in_valid && !in_stall) begin
				strip_predict(in_byte);
				taken_cnt++;
			end
			// free to move on only when nothing sits stalled on the port
			if (!(in_valid && in_stall)) begin
				if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
					in_valid <= 1'b1;
					in_byte  <= text_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check every taken output word, then stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) check_word(out_byte, last);
			out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
		end
	end

	// Drop the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleCap) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		scan_st   = csscs_pkg::MODE_PLAIN;
		taken_cnt = 0;
		errors    = 0;
		cycles    = 0;
		build_text();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// wait for the text to drain, then for the last expected word
		while (text_q.size() != 0 || in_valid) @(negedge clk);
		while (kept_q.size() != 0) @(negedge clk);
		// let any stray word show up
		repeat (TailWait) @(negedge clk);
		if (errors == 0 && kept_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
